[rtl/emi_pkg.sv]
package emi_pkg;

    localparam int ANGLE_BITS = 10;
    localparam int SUM_WIDTH  = 24;

    localparam int ONE = 1 << ANGLE_BITS;

    // supercluster limits as integer thresholds on |eta|
    localparam logic [12:0] SC_MAX_ACC   = 13'((25 * ONE) / 10);
    localparam logic [12:0] SC_CRACK_LO  = 13'((14442 * ONE) / 10000);
    localparam logic [12:0] SC_CRACK_HI  = 13'((1566 * ONE - 1) / 1000);
    localparam logic [12:0] SC_ENDCAP    = 13'((1479 * ONE) / 1000);

    localparam logic [15:0] PT_LOW_LIMIT = 16'd320;
    localparam int TWO_PI_FIX = ((205887 << ANGLE_BITS) + 16384) >> 15;
    localparam int PI_FIX     = TWO_PI_FIX / 2;

    localparam logic [8:0] CODE_MIN     = 9'd7;
    localparam logic [8:0] CODE_PHOTON  = 9'd22;
    localparam logic [8:0] CODE_NEUTRAL = 9'd130;
    localparam logic [8:0] CODE_CHARGED = 9'd211;

    // sum slots
    localparam logic [1:0] SUM_PH = 2'd0;
    localparam logic [1:0] SUM_NH = 2'd1;
    localparam logic [1:0] SUM_CH = 2'd2;
    localparam logic [1:0] SUM_PU = 2'd3;
    // dead cone slots in the packed register
    localparam logic [1:0] DC_CH = 2'd0;
    localparam logic [1:0] DC_PU = 2'd1;
    localparam logic [1:0] DC_PH = 2'd2;
    localparam logic [1:0] DC_NH = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_CONE_MIN   = 3'd0;
    localparam logic [2:0] CFG_CONE_MAX   = 3'd1;
    localparam logic [2:0] CFG_CONE_SCALE = 3'd2;
    localparam logic [2:0] CFG_PT_FLOOR   = 3'd3;
    localparam logic [2:0] CFG_DC_BARREL  = 3'd4;
    localparam logic [2:0] CFG_DC_ENDCAP  = 3'd5;

    // shared multiplier
    localparam int MA_W = 26;
    localparam int MB_W = 31;
    localparam int MP_W = MA_W + MB_W;
    localparam int R2_W = 24;
    localparam int D2_W = 29;
    localparam int CORR_SHIFT = 2 * ANGLE_BITS + 10;

    // floor(y / 9) as a reciprocal multiply, exact for y below 2^27
    localparam int Y_W = MP_W - CORR_SHIFT;
    localparam logic [MA_W-1:0] RECIP_9 = 26'd59652324;
    localparam int RECIP_SHIFT = 29;

    localparam int DIV_A = 16 + ANGLE_BITS;
    localparam int DIV_B = SUM_WIDTH + 12;
    localparam int DIV_C = MP_W - CORR_SHIFT;
    localparam int DIV_AB = (DIV_A > DIV_B) ? DIV_A : DIV_B;
    localparam int DIV_W = (DIV_AB > DIV_C) ? DIV_AB : DIV_C;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

endpackage

[rtl/emi_div.sv]
module emi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [emi_pkg::DIV_W-1:0]   i_dividend,
    input  logic [15:0]                 i_divisor,
    output logic                        o_done,
    output logic [emi_pkg::DIV_W-1:0]   o_quotient
);

    logic [15:0]                      r_rem;
    logic [15:0]                      r_div;
    logic [emi_pkg::DIV_W-1:0]        r_quo;
    logic [emi_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic [16:0] rem_sh;
    logic        ge;
    logic [16:0] rem_sub;

    assign rem_sh  = {r_rem, r_quo[emi_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= emi_pkg::DIV_CNT_W'(emi_pkg::DIV_W);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // one quotient bit a cycle, restoring
                r_rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
                r_quo <= {r_quo[emi_pkg::DIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == emi_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/electron_mini_isolation_top.sv]
// electron mini-isolation with a pt dependent cone
// input channel: i_in_valid / o_in_stall, one request per electron or candidate.
// an electron request outside the rejected eta regions opens a record, candidate
// requests add to four class sums, the request flagged last closes an open record
// and yields one result request on o_out_valid / i_out_stall.
// an ignored candidate is dropped in S_IDLE, a summed candidate passes S_SQA, S_SQB,
// S_DC and S_ACC, an electron with pt above PT_LOW_LIMIT passes S_CONE (cone
// radius division on the shared bit-serial divider, DIV_W = 36 quotient bits)
// and S_R2, a low-pt electron stays in S_IDLE. the closing request passes S_FIN,
// S_CMUL and S_CREC (pileup term on the shared multiplier), then S_DIVS and
// S_RWAIT (one divider run) to the output register; a low-pt close skips to S_OUT.
// o_in_stall is high whenever the sequencer is busy.
// reset (synchronous, active low) restores register defaults, closes the record
// and empties the output register.
// when the receiver stalls, the result holds in the output register; the block
// finishes the next item but waits with a further result until the register frees.
module electron_mini_isolation_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_command,
    input  logic [15:0]         i_pt,
    input  logic signed [13:0]  i_eta,
    input  logic signed [12:0]  i_phi,
    input  logic [12:0]         i_cluster_eta_abs,
    input  logic [9:0]          i_effective_area,
    input  logic [12:0]         i_energy_density,
    input  logic [8:0]          i_particle_code,
    input  logic                i_is_neutral,
    input  logic [1:0]          i_vertex_quality,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [15:0]         o_relative_isolation,
    output logic                o_low_pt,
    output logic                o_saturated
);

    localparam int SW = emi_pkg::SUM_WIDTH;
    localparam int DW = emi_pkg::DIV_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0_0000_0000_0001,
        S_CONE  = 13'b0_0000_0000_0010,
        S_R2    = 13'b0_0000_0000_0100,
        S_SQA   = 13'b0_0000_0000_1000,
        S_SQB   = 13'b0_0000_0001_0000,
        S_DC    = 13'b0_0000_0010_0000,
        S_ACC   = 13'b0_0000_0100_0000,
        S_FIN   = 13'b0_0000_1000_0000,
        S_CMUL  = 13'b0_0001_0000_0000,
        S_CREC  = 13'b0_0010_0000_0000,
        S_DIVS  = 13'b0_0100_0000_0000,
        S_RWAIT = 13'b0_1000_0000_0000,
        S_OUT   = 13'b1_0000_0000_0000
    } t_state;

    t_state r_state;

    logic [11:0] r_cone_min, r_cone_max;
    logic [15:0] r_cone_scale, r_floor;
    logic [47:0] r_dc_barrel, r_dc_endcap;

    logic [15:0]              r_e_pt;
    logic signed [13:0]       r_e_eta;
    logic signed [12:0]       r_e_phi;
    logic                     r_endcap, r_open, r_last;
    logic [11:0]              r_r;
    logic [emi_pkg::R2_W-1:0] r_r2;
    logic [23:0]              r_atr;
    logic [SW-1:0]            r_sum [4];
    logic [13:0]              r_ade, r_adp;
    logic [15:0]              r_cpt;
    logic [1:0]               r_ksum, r_kdc;
    logic                     r_elig;
    logic [emi_pkg::D2_W-1:0] r_d2;
    logic [emi_pkg::R2_W-1:0] r_dc2;
    logic [emi_pkg::MB_W-1:0] r_p;
    logic [emi_pkg::Y_W-1:0]  r_y;
    logic [emi_pkg::Y_W-1:0]  r_corr;
    logic [15:0]              r_res_rel;
    logic                     r_res_low, r_res_sat;
    logic                     r_ov;
    logic [15:0]              r_o_rel;
    logic                     r_o_low, r_o_sat;

    logic accept;
    assign o_in_stall = r_state != S_IDLE;
    assign accept     = i_in_valid && !o_in_stall;

    // shared multiplier
    logic [emi_pkg::MA_W-1:0] m_a;
    logic [emi_pkg::MB_W-1:0] m_b;
    logic [emi_pkg::MP_W-1:0] m_p;
    logic [11:0]              dc_sel;
    logic [47:0]              dc_reg;

    assign dc_reg = r_endcap ? r_dc_endcap : r_dc_barrel;
    assign dc_sel = dc_reg[12 * r_kdc +: 12];

    always_comb begin
        case (r_state)
            S_IDLE: begin
                m_a = emi_pkg::MA_W'(i_effective_area);
                m_b = emi_pkg::MB_W'(i_energy_density);
            end
            S_R2: begin
                m_a = emi_pkg::MA_W'(r_r);
                m_b = emi_pkg::MB_W'(r_r);
            end
            S_SQA: begin
                m_a = emi_pkg::MA_W'(r_ade);
                m_b = emi_pkg::MB_W'(r_ade);
            end
            S_SQB: begin
                m_a = emi_pkg::MA_W'(r_adp);
                m_b = emi_pkg::MB_W'(r_adp);
            end
            S_DC: begin
                m_a = emi_pkg::MA_W'(dc_sel);
                m_b = emi_pkg::MB_W'(dc_sel);
            end
            S_FIN: begin
                m_a = emi_pkg::MA_W'(r_r2);
                m_b = emi_pkg::MB_W'(100);
            end
            S_CMUL: begin
                m_a = emi_pkg::MA_W'(r_atr);
                m_b = r_p;
            end
            S_CREC: begin
                m_a = emi_pkg::RECIP_9;
                m_b = emi_pkg::MB_W'(r_y);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = emi_pkg::MP_W'(m_a) * emi_pkg::MP_W'(m_b);

    // shared divider
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [15:0]   div_divisor;
    logic          div_done;
    logic [DW-1:0] div_q;

    emi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // electron decode
    logic e_reject, e_endcap, e_high;
    assign e_reject = (i_cluster_eta_abs > emi_pkg::SC_MAX_ACC) ||
                      (i_cluster_eta_abs > emi_pkg::SC_CRACK_LO &&
                       i_cluster_eta_abs <= emi_pkg::SC_CRACK_HI);
    assign e_endcap = i_cluster_eta_abs > emi_pkg::SC_ENDCAP;
    assign e_high   = i_pt > emi_pkg::PT_LOW_LIMIT;

    // candidate decode
    logic       c_elig;
    logic [1:0] c_ksum, c_kdc;
    logic       c_floor;
    assign c_floor = i_pt > r_floor;

    always_comb begin
        c_elig = 1'b0;
        c_ksum = emi_pkg::SUM_PU;
        c_kdc  = emi_pkg::DC_PU;
        if (i_is_neutral) begin
            if (i_particle_code == emi_pkg::CODE_PHOTON) begin
                c_elig = c_floor;
                c_ksum = emi_pkg::SUM_PH;
                c_kdc  = emi_pkg::DC_PH;
            end else if (i_particle_code == emi_pkg::CODE_NEUTRAL) begin
                c_elig = c_floor;
                c_ksum = emi_pkg::SUM_NH;
                c_kdc  = emi_pkg::DC_NH;
            end
        end else if (i_vertex_quality > 2'd1) begin
            c_elig = i_particle_code == emi_pkg::CODE_CHARGED;
            c_ksum = emi_pkg::SUM_CH;
            c_kdc  = emi_pkg::DC_CH;
        end else begin
            c_elig = c_floor;
        end
    end

    logic signed [14:0] de, dp, dpw;
    logic [14:0]        ade15, adp15;
    assign de  = 15'(i_eta) - 15'(r_e_eta);
    assign dp  = 15'(i_phi) - 15'(r_e_phi);
    always_comb begin
        if (dp > 15'(emi_pkg::PI_FIX))
            dpw = dp - 15'(emi_pkg::TWO_PI_FIX);
        else if (dp < -15'(emi_pkg::PI_FIX))
            dpw = dp + 15'(emi_pkg::TWO_PI_FIX);
        else
            dpw = dp;
    end
    assign ade15 = de[14] ? 15'(-de) : 15'(de);
    assign adp15 = dpw[14] ? 15'(-dpw) : 15'(dpw);

    // cone clamp
    logic [11:0] cone_q;
    logic [11:0] cone_r;
    assign cone_q = (div_q > DW'(r_cone_max)) ? r_cone_max : div_q[11:0];
    assign cone_r = (cone_q < r_cone_min) ? r_cone_min : cone_q;

    // final combination
    logic [DW-1:0] neu, diff, tot;
    assign neu  = DW'(r_sum[emi_pkg::SUM_PH]) + DW'(r_sum[emi_pkg::SUM_NH]);
    assign diff = (neu > DW'(r_corr)) ? neu - DW'(r_corr) : '0;
    assign tot  = DW'(r_sum[emi_pkg::SUM_CH]) + diff;

    // saturating accumulate
    logic [SW:0] acc_sum;
    logic        in_cone;
    assign acc_sum = {1'b0, r_sum[r_ksum]} + (SW + 1)'(r_cpt);
    assign in_cone = r_elig && (r_d2 <= emi_pkg::D2_W'(r_r2)) &&
                     (r_d2 >= emi_pkg::D2_W'(r_dc2));

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_e_pt;
        case (r_state)
            S_IDLE: begin
                div_start    = accept && !i_command && !e_reject && e_high;
                div_dividend = DW'({r_cone_scale, {emi_pkg::ANGLE_BITS{1'b0}}});
                div_divisor  = i_pt;
            end
            S_DIVS: begin
                div_start    = 1'b1;
                div_dividend = tot << 10;
                div_divisor  = r_e_pt;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    logic out_free;
    assign out_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cone_min   <= 12'd51;
            r_cone_max   <= 12'd205;
            r_cone_scale <= 16'd640;
            r_floor      <= 16'd0;
            r_dc_barrel  <= 48'd0;
            r_dc_endcap  <= 48'd1375793167;
            r_e_pt       <= '0;
            r_e_eta      <= '0;
            r_e_phi      <= '0;
            r_endcap     <= 1'b0;
            r_open       <= 1'b0;
            r_r          <= '0;
            r_r2         <= '0;
            r_atr        <= '0;
            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    emi_pkg::CFG_CONE_MIN:   r_cone_min   <= i_cfg_data[11:0];
                    emi_pkg::CFG_CONE_MAX:   r_cone_max   <= i_cfg_data[11:0];
                    emi_pkg::CFG_CONE_SCALE: r_cone_scale <= i_cfg_data[15:0];
                    emi_pkg::CFG_PT_FLOOR:   r_floor      <= i_cfg_data[15:0];
                    emi_pkg::CFG_DC_BARREL:  r_dc_barrel  <= i_cfg_data;
                    emi_pkg::CFG_DC_ENDCAP:  r_dc_endcap  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_OUT && out_free) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_last;
                        if (!i_command) begin
                            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
                            if (e_reject) begin
                                r_open <= 1'b0;
                            end else begin
                                r_open   <= 1'b1;
                                r_e_pt   <= i_pt;
                                r_e_eta  <= i_eta;
                                r_e_phi  <= i_phi;
                                r_endcap <= e_endcap;
                                r_atr    <= m_p[23:0];
                                if (e_high) begin
                                    r_state <= S_CONE;
                                end else begin
                                    r_r  <= '0;
                                    r_r2 <= '0;
                                    if (i_last) r_state <= S_FIN;
                                end
                            end
                        end else if (r_open) begin
                            if (r_e_pt > emi_pkg::PT_LOW_LIMIT &&
                                i_particle_code >= emi_pkg::CODE_MIN) begin
                                r_ade   <= ade15[13:0];
                                r_adp   <= adp15[13:0];
                                r_cpt   <= i_pt;
                                r_ksum  <= c_ksum;
                                r_kdc   <= c_kdc;
                                r_elig  <= c_elig;
                                r_state <= S_SQA;
                            end else if (i_last) begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_CONE: begin
                    if (div_done) begin
                        r_r     <= cone_r;
                        r_state <= S_R2;
                    end
                end
                S_R2: begin
                    r_r2    <= m_p[emi_pkg::R2_W-1:0];
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_SQA: begin
                    r_d2    <= m_p[emi_pkg::D2_W-1:0];
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_d2    <= r_d2 + m_p[emi_pkg::D2_W-1:0];
                    r_state <= S_DC;
                end
                S_DC: begin
                    r_dc2   <= m_p[emi_pkg::R2_W-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (in_cone)
                        r_sum[r_ksum] <= acc_sum[SW] ? {SW{1'b1}} : acc_sum[SW-1:0];
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_open <= 1'b0;
                    if (r_e_pt <= emi_pkg::PT_LOW_LIMIT) begin
                        r_res_rel <= 16'hFFFF;
                        r_res_low <= 1'b1;
                        r_res_sat <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_p     <= m_p[emi_pkg::MB_W-1:0];
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    r_y     <= emi_pkg::Y_W'(m_p >> emi_pkg::CORR_SHIFT);
                    r_state <= S_CREC;
                end
                S_CREC: begin
                    r_corr  <= emi_pkg::Y_W'(m_p >> emi_pkg::RECIP_SHIFT);
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (div_done) begin
                        r_res_sat <= div_q[DW-1:16] != '0;
                        r_res_rel <= (div_q[DW-1:16] != '0) ? 16'hFFFF : div_q[15:0];
                        r_res_low <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_rel <= r_res_rel;
                        r_o_low <= r_res_low;
                        r_o_sat <= r_res_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid          = r_ov;
    assign o_relative_isolation = r_o_rel;
    assign o_low_pt             = r_o_low;
    assign o_saturated          = r_o_sat;

endmodule

[rtl/emi_checker.sv]
module emi_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [15:0]         o_relative_isolation,
    input  logic                o_low_pt,
    input  logic                o_saturated
);

    // a stalled result request holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
        $stable(o_relative_isolation) && $stable(o_low_pt) && $stable(o_saturated))
        else $error("stalled result changed");

    a_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_low_pt |-> o_relative_isolation == 16'hFFFF && !o_saturated)
        else $error("low pt sentinel wrong");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_relative_isolation == 16'hFFFF)
        else $error("saturated value not clipped");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not empty the block");

endmodule

bind electron_mini_isolation_top emi_checker u_emi_checker (.*);
